// ===== rtl/iec104_pkg.sv =====
// Shared constants, types and helpers for the IEC 104 APCI receiver.
`default_nettype none
package iec104_pkg;

  localparam int MAX_FRAME = 255;
  localparam int LEN_W     = 9;
  localparam int SEQ_W     = 15;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;
  localparam int QCNT_W    = 3;
  localparam int STEP_W    = 3;

  localparam logic [LEN_W-1:0]  MIN_LEN   = LEN_W'(6);
  localparam logic [LEN_W-1:0]  MAX_LEN   = LEN_W'(MAX_FRAME);
  localparam logic [LEN_W-1:0]  TID_INDEX = LEN_W'(6);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(6);

  localparam logic [7:0] START_BYTE    = 8'h68;
  localparam logic [7:0] APCI_LEN      = 8'h04;
  localparam logic [7:0] S_CTRL        = 8'h01;
  localparam logic [7:0] ZERO_BYTE     = 8'h00;
  localparam logic [7:0] U_STARTDT_CON = 8'h0B;
  localparam logic [7:0] U_STOPDT_CON  = 8'h23;
  localparam logic [7:0] U_TESTFR_ACT  = 8'h43;
  localparam logic [7:0] U_TESTFR_CON  = 8'h83;
  localparam logic [7:0] TID_NO_ACK    = 8'd100;

  localparam logic [1:0] FK_I = 2'd0;
  localparam logic [1:0] FK_S = 2'd1;
  localparam logic [1:0] FK_U = 2'd2;

  localparam logic ITEM_RESP   = 1'b0;
  localparam logic ITEM_REPORT = 1'b1;

  typedef enum logic [1:0] {
    RESP_NONE,
    RESP_SACK,
    RESP_TESTCON
  } resp_t;

  typedef struct packed {
    logic [1:0]       fkind;
    logic [7:0]       tid;
    logic             started;
    logic             tested;
    logic [SEQ_W-1:0] send;
    logic [SEQ_W-1:0] recv;
    resp_t            resp;
  } job_t;

  function automatic logic [7:0] resp_byte(resp_t r, logic [STEP_W-1:0] idx,
                                           logic [SEQ_W-1:0] recv);
    logic [7:0] b;
    b = ZERO_BYTE;
    case (idx)
      STEP_W'(1): b = START_BYTE;
      STEP_W'(2): b = APCI_LEN;
      STEP_W'(3): b = (r == RESP_SACK) ? S_CTRL : U_TESTFR_CON;
      STEP_W'(5): b = (r == RESP_SACK) ? {recv[6:0], 1'b0} : ZERO_BYTE;
      STEP_W'(6): b = (r == RESP_SACK) ? recv[14:7] : ZERO_BYTE;
      default:    b = ZERO_BYTE;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/iec104_front.sv =====
// Byte parser: frame hunt, collection, classification and link state update.
`default_nettype none
module iec104_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       rx_byte,
  input  wire logic             q_full,
  output logic                  push,
  output iec104_pkg::job_t      push_job
);
  import iec104_pkg::*;

  typedef enum logic [1:0] {HUNT, LENGTH, BODY} phase_t;

  phase_t           phase;
  logic [LEN_W-1:0] frame_length;
  logic [LEN_W-1:0] byte_index;
  logic [7:0]       ctrl [4];
  logic [7:0]       type_id;
  logic [SEQ_W-1:0] send_counter;
  logic [SEQ_W-1:0] recv_counter;
  logic             started_flag;
  logic             tested_flag;

  logic [7:0]       ctrl_next [4];
  logic [7:0]       type_id_next;
  logic [LEN_W-1:0] idx_inc;
  logic [LEN_W-1:0] len_cand;
  logic             done;
  logic             accept;
  job_t             job;

  assign idx_inc  = byte_index + LEN_W'(1);
  assign len_cand = {1'b0, rx_byte} + LEN_W'(2);
  assign done     = (phase == BODY) && (idx_inc >= frame_length);
  assign in_ready = !(done && q_full);
  assign accept   = in_valid && in_ready;
  assign push     = accept && done;
  assign push_job = job;

  always_comb begin
    ctrl_next    = ctrl;
    type_id_next = type_id;
    if (byte_index >= LEN_W'(2) && byte_index <= LEN_W'(5)) begin
      ctrl_next[byte_index[1:0] - 2'd2] = rx_byte;
    end else if (byte_index == TID_INDEX) begin
      type_id_next = rx_byte;
    end
  end

  always_comb begin
    job.fkind   = FK_I;
    job.tid     = ZERO_BYTE;
    job.started = started_flag;
    job.tested  = tested_flag;
    job.send    = send_counter;
    job.recv    = recv_counter;
    job.resp    = RESP_NONE;
    if (!ctrl_next[0][0]) begin
      job.fkind = FK_I;
      job.tid   = type_id_next;
      job.send  = {ctrl_next[3], ctrl_next[2][7:1]};
      job.recv  = {ctrl_next[1], ctrl_next[0][7:1]} + SEQ_W'(1);
      if (type_id_next != TID_NO_ACK) begin
        job.resp = RESP_SACK;
      end
    end else if (!ctrl_next[0][1]) begin
      job.fkind = FK_S;
    end else begin
      job.fkind = FK_U;
      unique case (ctrl_next[0])
        U_STARTDT_CON: begin
          job.started = 1'b1;
          job.send    = '0;
          job.recv    = '0;
        end
        U_STOPDT_CON: begin
          job.started = 1'b0;
          job.send    = '0;
          job.recv    = '0;
        end
        U_TESTFR_ACT: begin
          job.tested = 1'b0;
          job.resp   = RESP_TESTCON;
        end
        U_TESTFR_CON: begin
          job.tested = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= HUNT;
      frame_length <= '0;
      byte_index   <= '0;
      ctrl         <= '{default: '0};
      type_id      <= '0;
      send_counter <= '0;
      recv_counter <= '0;
      started_flag <= 1'b0;
      tested_flag  <= 1'b1;
    end else if (accept) begin
      unique case (phase)
        HUNT: begin
          if (rx_byte == START_BYTE) begin
            phase <= LENGTH;
          end
        end
        LENGTH: begin
          if (len_cand >= MIN_LEN && len_cand <= MAX_LEN) begin
            frame_length <= len_cand;
            byte_index   <= LEN_W'(2);
            phase        <= BODY;
          end else begin
            phase <= HUNT;
          end
        end
        BODY: begin
          ctrl       <= ctrl_next;
          type_id    <= type_id_next;
          byte_index <= idx_inc;
          if (done) begin
            phase        <= HUNT;
            send_counter <= job.send;
            recv_counter <= job.recv;
            started_flag <= job.started;
            tested_flag  <= job.tested;
          end
        end
        default: phase <= HUNT;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/iec104_queue.sv =====
// Short job queue between the parser and the result emitter.
`default_nettype none
module iec104_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  iec104_pkg::job_t      push_job,
  input  wire logic             pop,
  output logic                  full,
  output logic                  empty,
  output iec104_pkg::job_t      head
);
  import iec104_pkg::*;

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/iec104_back.sv =====
// Result emitter: one report item, then any response bytes, through an output register.
`default_nettype none
module iec104_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_empty,
  input  iec104_pkg::job_t                 head,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             item_kind,
  output logic [7:0]                       tx_byte,
  output logic                             last_of_run,
  output logic [1:0]                       frame_kind,
  output logic [7:0]                       frame_type_id,
  output logic                             link_started,
  output logic                             test_pending,
  output logic [iec104_pkg::SEQ_W-1:0]     send_seq,
  output logic [iec104_pkg::SEQ_W-1:0]     recv_seq
);
  import iec104_pkg::*;

  logic [STEP_W-1:0] step;
  logic              load;
  logic              is_last;

  assign load    = !out_valid || out_ready;
  assign is_last = (step == '0) ? (head.resp == RESP_NONE) : (step == LAST_STEP);
  assign pop     = load && !q_empty && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
    end else if (load) begin
      out_valid <= !q_empty;
      if (!q_empty) begin
        step <= is_last ? '0 : step + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      last_of_run <= is_last;
      if (step == '0) begin
        item_kind     <= ITEM_REPORT;
        tx_byte       <= ZERO_BYTE;
        frame_kind    <= head.fkind;
        frame_type_id <= head.tid;
        link_started  <= head.started;
        test_pending  <= head.tested;
        send_seq      <= head.send;
        recv_seq      <= head.recv;
      end else begin
        item_kind     <= ITEM_RESP;
        tx_byte       <= resp_byte(head.resp, step, head.recv);
        frame_kind    <= FK_I;
        frame_type_id <= ZERO_BYTE;
        link_started  <= 1'b0;
        test_pending  <= 1'b0;
        send_seq      <= '0;
        recv_seq      <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/iec104_apdu_receiver_core.sv =====
// Top level of the IEC 104 APCI receiver: parser, job queue and emitter.
//
//  channel | valid     | ready     | payload
//  --------+-----------+-----------+----------------------------------------------
//  in      | in_valid  | in_ready  | rx_byte
//  out     | out_valid | out_ready | item_kind tx_byte last_of_run frame_kind
//          |           |           | frame_type_id link_started test_pending
//          |           |           | send_seq recv_seq
//
// One byte is taken per cycle while in_ready is high; a completed frame becomes a job in a four-entry queue.
// The emitter sends one item per cycle while out_ready is high: one report plus up to six response bytes.
// After a frame's last byte is taken, its job is written to a queue slot and then loaded into the output register.
// in_ready falls only on a frame's last byte while the queue is full.
// Synchronous reset clears the parser, queue pointers and output valid.
`default_nettype none
module iec104_apdu_receiver_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [7:0]                  rx_byte,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             item_kind,
  output logic [7:0]                       tx_byte,
  output logic                             last_of_run,
  output logic [1:0]                       frame_kind,
  output logic [7:0]                       frame_type_id,
  output logic                             link_started,
  output logic                             test_pending,
  output logic [iec104_pkg::SEQ_W-1:0]     send_seq,
  output logic [iec104_pkg::SEQ_W-1:0]     recv_seq
);
  import iec104_pkg::*;

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  job_t push_job;
  job_t head;

  iec104_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  iec104_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head)
  );

  iec104_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .item_kind     (item_kind),
    .tx_byte       (tx_byte),
    .last_of_run   (last_of_run),
    .frame_kind    (frame_kind),
    .frame_type_id (frame_type_id),
    .link_started  (link_started),
    .test_pending  (test_pending),
    .send_seq      (send_seq),
    .recv_seq      (recv_seq)
  );

endmodule
`default_nettype wire

// ===== tb/iec104_apdu_receiver_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench for the IEC 104 APCI receiver core: directed and random byte streams.
module iec104_apdu_receiver_core_tb;
  import iec104_pkg::*;

  localparam int unsigned RANDOM_BYTES     = 80;
  localparam int unsigned LONG_HOLD_CYCLES = 250;
  localparam int unsigned DRAIN_CYCLES     = 16;
  localparam int unsigned TIMEOUT_NS       = 3_000_000;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LEN,
    PH_BODY
  } rx_phase_t;

  typedef struct packed {
    logic             kind;
    logic [7:0]       txb;
    logic             last;
    logic [1:0]       fkind;
    logic [7:0]       tid;
    logic             started;
    logic             tested;
    logic [SEQ_W-1:0] snd;
    logic [SEQ_W-1:0] rcv;
  } apdu_item_t;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic [7:0]       rx_byte;
  logic             out_valid;
  logic             out_ready;
  logic             item_kind;
  logic [7:0]       tx_byte;
  logic             last_of_run;
  logic [1:0]       frame_kind;
  logic [7:0]       frame_type_id;
  logic             link_started;
  logic             test_pending;
  logic [SEQ_W-1:0] send_seq;
  logic [SEQ_W-1:0] recv_seq;

  apdu_item_t pending_items[$];

  rx_phase_t        rx_phase  = PH_HUNT;
  logic [LEN_W-1:0] rx_len    = '0;
  logic [LEN_W-1:0] rx_idx    = '0;
  logic [7:0]       ctl[4]    = '{8'h00, 8'h00, 8'h00, 8'h00};
  logic [7:0]       kept_tid  = 8'h00;
  logic [SEQ_W-1:0] snd_ctr   = '0;
  logic [SEQ_W-1:0] rcv_ctr   = '0;
  logic             link_up   = 1'b0;
  logic             test_wait = 1'b1;

  bit tx_idle_en   = 1'b0;
  bit rx_idle_en   = 1'b0;
  bit hold_request = 1'b0;

  int unsigned fault_count  = 0;
  int unsigned bytes_sent   = 0;
  int unsigned frames_built = 0;
  int unsigned reports_seen = 0;
  int unsigned resp_seen    = 0;

  iec104_apdu_receiver_core dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .item_kind     (item_kind),
    .tx_byte       (tx_byte),
    .last_of_run   (last_of_run),
    .frame_kind    (frame_kind),
    .frame_type_id (frame_type_id),
    .link_started  (link_started),
    .test_pending  (test_pending),
    .send_seq      (send_seq),
    .recv_seq      (recv_seq)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timed out with %0d results outstanding", $time, pending_items.size());
    $display("== FAIL ==");
    $finish;
  end

  function automatic void close_frame();
    logic [7:0]  tx_q[$];
    logic [15:0] ack;
    logic [1:0]  fk;
    logic [7:0]  tid;
    apdu_item_t  itm;
    fk  = FK_U;
    tid = 8'h00;
    if (!ctl[0][0]) begin
      fk      = FK_I;
      snd_ctr = {ctl[3], ctl[2][7:1]};
      rcv_ctr = {ctl[1], ctl[0][7:1]} + 15'd1;
      tid     = kept_tid;
      if (kept_tid != TID_NO_ACK) begin
        ack  = {rcv_ctr, 1'b0};
        tx_q = '{START_BYTE, APCI_LEN, S_CTRL, ZERO_BYTE, ack[7:0], ack[15:8]};
      end
    end else if (!ctl[0][1]) begin
      fk = FK_S;
    end else begin
      case (ctl[0])
        U_STARTDT_CON: begin
          link_up = 1'b1;
          snd_ctr = '0;
          rcv_ctr = '0;
        end
        U_STOPDT_CON: begin
          link_up = 1'b0;
          snd_ctr = '0;
          rcv_ctr = '0;
        end
        U_TESTFR_ACT: begin
          tx_q = '{START_BYTE, APCI_LEN, U_TESTFR_CON, ZERO_BYTE, ZERO_BYTE, ZERO_BYTE};
          test_wait = 1'b0;
        end
        U_TESTFR_CON: test_wait = 1'b0;
        default: ;
      endcase
    end
    itm         = '0;
    itm.kind    = ITEM_REPORT;
    itm.last    = (tx_q.size() == 0);
    itm.fkind   = fk;
    itm.tid     = tid;
    itm.started = link_up;
    itm.tested  = test_wait;
    itm.snd     = snd_ctr;
    itm.rcv     = rcv_ctr;
    pending_items.push_back(itm);
    foreach (tx_q[i]) begin
      itm      = '0;
      itm.kind = ITEM_RESP;
      itm.txb  = tx_q[i];
      itm.last = (i == tx_q.size() - 1);
      pending_items.push_back(itm);
    end
  endfunction

  function automatic void absorb_rx_byte(logic [7:0] b);
    logic [LEN_W-1:0] n;
    case (rx_phase)
      PH_HUNT: if (b == START_BYTE) rx_phase = PH_LEN;
      PH_LEN: begin
        n = {1'b0, b} + LEN_W'(2);
        if (n >= MIN_LEN && n <= MAX_LEN) begin
          rx_len   = n;
          rx_idx   = LEN_W'(2);
          rx_phase = PH_BODY;
        end else begin
          rx_phase = PH_HUNT;
        end
      end
      default: begin
        if (rx_idx >= LEN_W'(2) && rx_idx < TID_INDEX) ctl[rx_idx - LEN_W'(2)] = b;
        else if (rx_idx == TID_INDEX) kept_tid = b;
        rx_idx = rx_idx + LEN_W'(1);
        if (rx_idx >= rx_len) begin
          rx_phase = PH_HUNT;
          close_frame();
        end
      end
    endcase
  endfunction

  function automatic void check_field(string fname, logic [15:0] want_v, logic [15:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, fname, want_v, got_v);
      fault_count++;
    end
  endfunction

  always @(posedge clk) begin
    apdu_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_items.size() == 0) begin
        $display("%0t: unexpected item: expected none, got kind %0d byte %02h",
                 $time, item_kind, tx_byte);
        fault_count++;
      end else begin
        want = pending_items.pop_front();
        check_field("item_kind", want.kind, item_kind);
        check_field("tx_byte", want.txb, tx_byte);
        check_field("last_of_run", want.last, last_of_run);
        check_field("frame_kind", want.fkind, frame_kind);
        check_field("frame_type_id", want.tid, frame_type_id);
        check_field("link_started", want.started, link_started);
        check_field("test_pending", want.tested, test_pending);
        check_field("send_seq", want.snd, send_seq);
        check_field("recv_seq", want.rcv, recv_seq);
        if (want.kind == ITEM_REPORT) reports_seen++;
        else resp_seen++;
      end
    end
  end

  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 18);
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic send_apdu(input logic [7:0] len_byte, input logic [7:0] c0, c1, c2, c3,
                           input logic [7:0] tid);
    logic [7:0]  head[5];
    logic [7:0]  b;
    int unsigned span;
    int unsigned k;
    head = '{c0, c1, c2, c3, tid};
    span = len_byte + 2;
    send_byte(START_BYTE);
    send_byte(len_byte);
    for (k = 2; k < span; k++) begin
      if (k < 7) b = head[k - 2];
      else b = ($urandom_range(0, 15) == 0) ? START_BYTE : 8'($urandom);
      send_byte(b);
    end
    frames_built++;
  endtask

  task automatic send_bad_header(input logic [7:0] len_byte);
    send_byte(START_BYTE);
    send_byte(len_byte);
  endtask

  task automatic send_random_apdu();
    logic [7:0]  c0, c1, c2, c3, tid, len_byte;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    c0  = 8'($urandom);
    c1  = 8'($urandom);
    c2  = 8'($urandom);
    c3  = 8'($urandom);
    if (sel < 45) begin
      c0[0] = 1'b0;
      if ($urandom_range(0, 7) == 0) begin
        c0 = 8'hFE;
        c1 = 8'hFF;
        c2 = 8'hFF;
        c3 = 8'hFF;
      end
    end else if (sel < 65) begin
      c0[1:0] = 2'b01;
    end else begin
      case ($urandom_range(0, 5))
        0: c0 = U_STARTDT_CON;
        1: c0 = U_STOPDT_CON;
        2: c0 = U_TESTFR_ACT;
        3: c0 = U_TESTFR_CON;
        default: c0[1:0] = 2'b11;
      endcase
    end
    tid = ($urandom_range(0, 4) == 0) ? TID_NO_ACK : 8'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 10) len_byte = 8'($urandom_range(15, 40));
    else len_byte = 8'($urandom_range(4, 14));
    send_apdu(len_byte, c0, c1, c2, c3, tid);
  endtask

  task automatic send_line_noise();
    logic [7:0]  b;
    int unsigned n;
    if ($urandom_range(0, 1) == 0) begin
      if ($urandom_range(0, 1) == 0) send_bad_header(8'($urandom_range(0, 3)));
      else send_bad_header(8'($urandom_range(254, 255)));
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        do b = 8'($urandom); while (b == START_BYTE);
        send_byte(b);
      end
    end
  endtask

  task automatic pause_input();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0) @(posedge clk);
  endtask

  task automatic test_u_frames();
    send_apdu(8'h04, U_STARTDT_CON, 8'h00, 8'h00, 8'h00, 8'h00);
    send_apdu(8'h04, U_TESTFR_ACT, 8'h00, 8'h00, 8'h00, 8'h00);
    send_apdu(8'h04, 8'h07, 8'h00, 8'h00, 8'h00, 8'h00);
    send_apdu(8'h04, U_TESTFR_CON, 8'h00, 8'h00, 8'h00, 8'h00);
    send_apdu(8'h04, U_STOPDT_CON, 8'h00, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_i_frames();
    send_apdu(8'h0E, 8'hFE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_apdu(8'h05, 8'h01, 8'h00, 8'h00, 8'h00, 8'h2D);
    send_apdu(8'h04, 8'h02, 8'h00, 8'h02, 8'h00, 8'h00);
    send_apdu(8'h0A, 8'h00, 8'h00, 8'h00, 8'h00, TID_NO_ACK);
    send_apdu(8'h06, START_BYTE, START_BYTE, START_BYTE, START_BYTE, START_BYTE);
  endtask

  task automatic test_frame_lengths();
    send_bad_header(8'h00);
    send_bad_header(8'h03);
    send_bad_header(8'hFE);
    send_bad_header(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_apdu(8'h1E, 8'h10, 8'h20, 8'h30, 8'h40, 8'h01);
    send_apdu(8'h04, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'h00);
  endtask

  task automatic test_random_traffic();
    int unsigned start_bytes;
    start_bytes = bytes_sent;
    rx_idle_en  = 1'b1;
    while (bytes_sent - start_bytes < RANDOM_BYTES) begin
      tx_idle_en = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) send_line_noise();
      else send_random_apdu();
    end
  endtask

  task automatic test_backpressure();
    tx_idle_en   = 1'b0;
    hold_request = 1'b1;
    repeat (12) send_apdu(8'h04, {7'($urandom), 1'b0}, 8'($urandom), 8'($urandom),
                          8'($urandom), 8'h00);
  endtask

  task automatic test_drain_pause();
    pause_input();
    wait_drained();
    tx_idle_en = 1'b1;
    repeat (3) send_random_apdu();
  endtask

  task automatic test_steady_stream();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (6) send_random_apdu();
  endtask

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    rx_byte  = 8'h00;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_u_frames();
    test_i_frames();
    test_frame_lengths();
    test_random_traffic();
    test_backpressure();
    test_drain_pause();
    test_steady_stream();
    pause_input();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d bytes in %0d built frames, with bad lengths, noise and a long stall",
             bytes_sent, frames_built);
    $display("Checked %0d frame reports and %0d response bytes", reports_seen, resp_seen);
    if (fault_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/iec104_pkg.sv
rtl/iec104_front.sv
rtl/iec104_queue.sv
rtl/iec104_back.sv
rtl/iec104_apdu_receiver_core.sv
tb/iec104_apdu_receiver_core_tb.sv
